// File: design/fp32a_pkg.sv
// ----------------------------------------------------------------------------
// fp32a_pkg
// shared types, constants and helpers of the single-precision adder pipeline
// ----------------------------------------------------------------------------
package fp32a_pkg;

    localparam logic [31:0] QNAN_OUT = 32'h7fff_ffff;
    localparam logic [31:0] EXP_SAT  = 32'h7f80_0000;
    localparam logic [7:0]  EXP_MAX  = 8'd255;
    localparam int          EXTRA    = 7;
    localparam int          LEAD_POS = 23 + EXTRA;

    // after unpack and swap
    typedef struct packed {
        logic        valid;
        logic        spec;
        logic [31:0] spec_val;
        logic        sa;
        logic        sb;
        logic [7:0]  e;
        logic [30:0] ma;
        logic [30:0] mb;
        logic [7:0]  d;
    } st1_t;

    // after alignment
    typedef struct packed {
        logic        valid;
        logic        spec;
        logic [31:0] spec_val;
        logic        sa;
        logic        sb;
        logic [7:0]  e;
        logic [30:0] ma;
        logic [30:0] mb;
    } st2_t;

    // after add or subtract
    typedef struct packed {
        logic        valid;
        logic        spec;
        logic [31:0] spec_val;
        logic        sign;
        logic [7:0]  e;
        logic [31:0] s;
    } st3_t;

    // after normalize
    typedef struct packed {
        logic        valid;
        logic        spec;
        logic [31:0] spec_val;
        logic        sign;
        logic        zero;
        logic [7:0]  big;
        logic [30:0] m;
    } st4_t;

    // position of the leading one, zero when none
    function automatic logic [4:0] lead_pos(input logic [31:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
                p = 5'(i);
        end
        return p;
    endfunction

endpackage

// File: design/fp32a_align.sv
// ----------------------------------------------------------------------------
// fp32a_align
// stages one and two: unpack, special cases, swap and sticky alignment
// ----------------------------------------------------------------------------
module fp32a_align (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         a,
    input  logic [31:0]         b,
    output fp32a_pkg::st2_t     st2
);

    fp32a_pkg::st1_t st1_reg, st1_next;
    fp32a_pkg::st2_t st2_reg, st2_next;

    logic [7:0]  xa, xb, ea, eb;
    logic [22:0] fa, fb;
    logic [30:0] ma, mb;
    logic        nan_a, nan_b, inf_a, inf_b;

    always_comb
    begin
        xa = a[30:23];
        xb = b[30:23];
        fa = a[22:0];
        fb = b[22:0];
        nan_a = (xa == fp32a_pkg::EXP_MAX) && (fa != 23'd0);
        nan_b = (xb == fp32a_pkg::EXP_MAX) && (fb != 23'd0);
        inf_a = (xa == fp32a_pkg::EXP_MAX);
        inf_b = (xb == fp32a_pkg::EXP_MAX);
        ma = {(xa != 8'd0), fa, 7'd0};
        mb = {(xb != 8'd0), fb, 7'd0};
        ea = (xa != 8'd0) ? xa : 8'd1;
        eb = (xb != 8'd0) ? xb : 8'd1;

        st1_next.valid = in_valid;
        st1_next.spec  = inf_a || inf_b;
        if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31])))
            st1_next.spec_val = fp32a_pkg::QNAN_OUT;
        else if (inf_a)
            st1_next.spec_val = a;
        else
            st1_next.spec_val = b;

        if (ea >= eb)
        begin
            st1_next.sa = a[31];
            st1_next.sb = b[31];
            st1_next.e  = ea;
            st1_next.ma = ma;
            st1_next.mb = mb;
            st1_next.d  = ea - eb;
        end
        else
        begin
            st1_next.sa = b[31];
            st1_next.sb = a[31];
            st1_next.e  = eb;
            st1_next.ma = mb;
            st1_next.mb = ma;
            st1_next.d  = eb - ea;
        end
    end

    // shift right with sticky jam into bit 0
    logic [30:0] shifted;
    logic [30:0] lost_mask;
    logic        sticky;

    always_comb
    begin
        if (st1_reg.d >= 8'd31)
        begin
            shifted   = 31'd0;
            lost_mask = {31{1'b1}};
        end
        else
        begin
            shifted   = st1_reg.mb >> st1_reg.d[4:0];
            lost_mask = ~({31{1'b1}} << st1_reg.d[4:0]);
        end
        sticky = |(st1_reg.mb & lost_mask);

        st2_next.valid    = st1_reg.valid;
        st2_next.spec     = st1_reg.spec;
        st2_next.spec_val = st1_reg.spec_val;
        st2_next.sa       = st1_reg.sa;
        st2_next.sb       = st1_reg.sb;
        st2_next.e        = st1_reg.e;
        st2_next.ma       = st1_reg.ma;
        st2_next.mb       = {shifted[30:1], shifted[0] | sticky};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_reg.valid <= 1'b0;
            st2_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
        end
    end

    assign st2 = st2_reg;

endmodule

// File: design/fp32a_mant.sv
// ----------------------------------------------------------------------------
// fp32a_mant
// stages three and four: magnitude add or subtract, leading-one normalize
// ----------------------------------------------------------------------------
module fp32a_mant (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  fp32a_pkg::st2_t     st2,
    output fp32a_pkg::st4_t     st4
);

    fp32a_pkg::st3_t st3_reg, st3_next;
    fp32a_pkg::st4_t st4_reg, st4_next;

    always_comb
    begin
        st3_next.valid    = st2.valid;
        st3_next.spec     = st2.spec;
        st3_next.spec_val = st2.spec_val;
        st3_next.e        = st2.e;
        if (st2.sa == st2.sb)
        begin
            st3_next.s    = {1'b0, st2.ma} + {1'b0, st2.mb};
            st3_next.sign = st2.sa;
        end
        else if (st2.ma > st2.mb)
        begin
            st3_next.s    = {1'b0, st2.ma - st2.mb};
            st3_next.sign = st2.sa;
        end
        else if (st2.mb > st2.ma)
        begin
            st3_next.s    = {1'b0, st2.mb - st2.ma};
            st3_next.sign = st2.sb;
        end
        else
        begin
            st3_next.s    = 32'd0;
            st3_next.sign = 1'b0;
        end
    end

    logic [4:0]        p;
    logic signed [9:0] er;
    logic [31:0]       sh;

    always_comb
    begin
        p  = fp32a_pkg::lead_pos(st3_reg.s);
        er = $signed({2'b00, st3_reg.e}) + $signed({5'd0, p})
             - 10'sd30;
        sh = 32'd0;

        st4_next.valid    = st3_reg.valid;
        st4_next.spec     = st3_reg.spec;
        st4_next.spec_val = st3_reg.spec_val;
        st4_next.sign     = st3_reg.sign;
        st4_next.zero     = (st3_reg.s == 32'd0);

        if (er >= 10'sd1)
        begin
            st4_next.big = er[7:0];
            if (p == 5'd31)
                st4_next.m = {st3_reg.s[31:2], st3_reg.s[1] | st3_reg.s[0]};
            else
            begin
                sh = st3_reg.s << (5'd30 - p);
                st4_next.m = sh[30:0];
            end
        end
        else
        begin
            // below the normal range, scale to exponent one
            st4_next.big = 8'd1;
            sh = st3_reg.s << (st3_reg.e[4:0] - 5'd1);
            st4_next.m = sh[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st3_reg.valid <= 1'b0;
            st4_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            st3_reg <= st3_next;
            st4_reg <= st4_next;
        end
    end

    assign st4 = st4_reg;

    // larger operand is normal unless its exponent is the subnormal one
    a_big_norm: assert property (@(posedge clk) disable iff (!rst_n)
        st2.valid && !st2.spec |-> st2.ma[30] || (st2.e == 8'd1))
        else $error("aligned larger operand lost its hidden bit");

    // normalized result or subnormal scale
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        st4_reg.valid && !st4_reg.spec && !st4_reg.zero
        |-> st4_reg.m[30] || (st4_reg.big == 8'd1))
        else $error("normalize stage left a leading zero");

    // a stalled stage holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(st4_reg) && $stable(st3_reg))
        else $error("stalled stage changed");

endmodule

// File: design/fp32_adder.sv
// ----------------------------------------------------------------------------
// fp32_adder
// ieee 754 single-precision adder, round to nearest even, five stages
// ----------------------------------------------------------------------------
// an accepted request passes the st1, st2, st3, st4 and output registers to the port
// throughput: one request per cycle; the whole pipe advances together and
//   holds only while the output register is full and not taken
// reset: rst_n clears every stage valid bit; data registers are not reset
// ----------------------------------------------------------------------------
module fp32_adder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a [31:0], operand_b [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // sum_bits [31:0]
);

    // common advance for every stage
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    fp32a_pkg::st2_t st2;
    fp32a_pkg::st4_t st4;

    // stages one and two: unpack, specials, swap, align with sticky
    fp32a_align u_align (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .a        (s_axis_tdata[31:0]),
        .b        (s_axis_tdata[63:32]),
        .st2      (st2)
    );

    // stages three and four: add or subtract, normalize
    fp32a_mant u_mant (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .st2   (st2),
        .st4   (st4)
    );

    // stage five: round to nearest even, pack, saturate to infinity
    logic        out_valid_reg;
    logic [31:0] out_data_reg, out_data_next;
    logic [23:0] r;
    logic [6:0]  rem;
    logic        rnd_up;
    logic [31:0] mag;

    always_comb
    begin
        r      = st4.m[30:7];
        rem    = st4.m[6:0];
        rnd_up = (rem > 7'h40) || ((rem == 7'h40) && r[0]);
        mag    = {1'b0, st4.big - 8'd1, 23'd0} + {8'd0, r} + {31'd0, rnd_up};
        if (mag >= fp32a_pkg::EXP_SAT)
            mag = fp32a_pkg::EXP_SAT;

        if (st4.spec)
            out_data_next = st4.spec_val;
        else if (st4.zero)
            out_data_next = {st4.sign, 31'd0};
        else
            out_data_next = {st4.sign, mag[30:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= st4.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
